@@ design/lightmap_bilinear_sampler_unit_macros.svh @@
// assertion macros for the lightmap bilinear sampler
`ifndef LIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define LIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define LBS_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define LBS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ design/lbs_pkg.sv @@
// shared types and constants of the lightmap bilinear sampler
`default_nettype none

package lbs_pkg;

    localparam int TEXEL_W      = 8;
    localparam int RGB_W        = 24;
    localparam int SUM_W        = 20;
    localparam int NUM_CORNERS  = 4;
    localparam int NUM_CHANNELS = 3;
    localparam int NUM_LANES    = NUM_CORNERS * NUM_CHANNELS;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // colour channel order inside a packed texel and inside a corner's lanes
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // corner order of the lanes
    localparam int CORNER_00 = 0;
    localparam int CORNER_01 = 1;
    localparam int CORNER_10 = 2;
    localparam int CORNER_11 = 3;

    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic add;      // the item's layer counts towards the sums
        logic clear;    // the item closes the surface: sums restart at zero
    } lane_ctl_t;

endpackage

`default_nettype wire

@@ design/lightmap_bilinear_sampler_unit.sv @@
// top level of the lightmap bilinear sampler: mac lanes and interpolation stages
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready  | four corner texels, scale, flags, fractions
//  m_      | out       | m_valid / m_ready  | red, green and blue level
//
// one layer item is taken every cycle while s_ready is high; twelve lanes multiply-accumulate in parallel
// the result of a surface passes through these registers after its last layer item:
//   sum snapshot, horizontal lerp, vertical lerp into the output register
// reset clears the sums and empties every stage, no sweep needed
// s_ready drops only when a held snapshot cannot move on because m_ready is low
`default_nettype none

`include "lightmap_bilinear_sampler_unit_macros.svh"

module lightmap_bilinear_sampler_unit #(
    parameter int FRAC_BITS  = 4,
    parameter int SCALE_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // layer items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lbs_pkg::RGB_W-1:0]    s_corner00_rgb,
    input  logic [lbs_pkg::RGB_W-1:0]    s_corner01_rgb,
    input  logic [lbs_pkg::RGB_W-1:0]    s_corner10_rgb,
    input  logic [lbs_pkg::RGB_W-1:0]    s_corner11_rgb,
    input  logic [SCALE_BITS-1:0]        s_layer_scale,
    input  logic                         s_layer_valid,
    input  logic [FRAC_BITS-1:0]         s_s_frac,
    input  logic [FRAC_BITS-1:0]         s_t_frac,
    input  logic                         s_last_layer,
    // interpolated colour
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lbs_pkg::SUM_W-1:0]    m_red_level,
    output logic [lbs_pkg::SUM_W-1:0]    m_green_level,
    output logic [lbs_pkg::SUM_W-1:0]    m_blue_level
);
    import lbs_pkg::*;

    // handshake and stage flow
    logic s_accept;
    logic snap_load;
    logic mid_load;
    logic out_load;
    logic snap_free;
    logic mid_free;
    logic out_free;

    lane_ctl_t lane_ctl;

    // corner texels as an array, corner order as in the lanes
    logic [RGB_W-1:0] corner_rgb [NUM_CORNERS];

    // running totals from the lanes, this item included
    logic [SUM_W-1:0] lane_total [NUM_LANES];

    // stage valid flags
    logic snap_vld_reg, snap_vld_next;
    logic mid_vld_reg,  mid_vld_next;
    logic out_vld_reg,  out_vld_next;

    // stage payloads
    logic [SUM_W-1:0]     snap_sum_reg [NUM_LANES];
    logic [FRAC_BITS-1:0] snap_sf_reg;
    logic [FRAC_BITS-1:0] snap_tf_reg;
    logic [SUM_W-1:0]     top_reg [NUM_CHANNELS];
    logic [SUM_W-1:0]     bot_reg [NUM_CHANNELS];
    logic [FRAC_BITS-1:0] mid_tf_reg;
    logic [SUM_W-1:0]     level_reg [NUM_CHANNELS];

    // interpolation results
    logic [SUM_W-1:0] top_val [NUM_CHANNELS];
    logic [SUM_W-1:0] bot_val [NUM_CHANNELS];
    logic [SUM_W-1:0] lvl_val [NUM_CHANNELS];

    // back-pressure runs from the output towards the input
    always_comb begin
        out_free  = !out_vld_reg || m_ready;
        mid_free  = !mid_vld_reg || out_free;
        snap_free = !snap_vld_reg || mid_free;
        s_ready   = snap_free;
        s_accept  = s_valid && s_ready;
        snap_load = s_accept && s_last_layer;
        mid_load  = snap_vld_reg && mid_free;
        out_load  = mid_vld_reg && out_free;

        lane_ctl.accept = s_accept;
        lane_ctl.add    = s_accept && s_layer_valid;
        lane_ctl.clear  = s_last_layer;

        corner_rgb[CORNER_00] = s_corner00_rgb;
        corner_rgb[CORNER_01] = s_corner01_rgb;
        corner_rgb[CORNER_10] = s_corner10_rgb;
        corner_rgb[CORNER_11] = s_corner11_rgb;
    end

    // twelve lanes, index corner * channels + channel
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        lbs_mac_lane #(
            .SCALE_BITS (SCALE_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (lane_ctl),
            .texel     (corner_rgb[i / NUM_CHANNELS][(i % NUM_CHANNELS) * TEXEL_W +: TEXEL_W]),
            .scale     (s_layer_scale),
            .sum_total (lane_total[i])
        );
    end

    // merge: per colour, lerp along s on both rows, then along t
    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_merge
        lbs_lerp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lerp_top (
            .a    (snap_sum_reg[CORNER_00 * NUM_CHANNELS + ch]),
            .b    (snap_sum_reg[CORNER_01 * NUM_CHANNELS + ch]),
            .frac (snap_sf_reg),
            .y    (top_val[ch])
        );

        lbs_lerp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lerp_bot (
            .a    (snap_sum_reg[CORNER_10 * NUM_CHANNELS + ch]),
            .b    (snap_sum_reg[CORNER_11 * NUM_CHANNELS + ch]),
            .frac (snap_sf_reg),
            .y    (bot_val[ch])
        );

        lbs_lerp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lerp_vert (
            .a    (top_reg[ch]),
            .b    (bot_reg[ch]),
            .frac (mid_tf_reg),
            .y    (lvl_val[ch])
        );
    end

    // stage occupancy
    always_comb begin
        snap_vld_next = snap_vld_reg;
        if (snap_load) begin
            snap_vld_next = 1'b1;
        end else if (mid_free) begin
            snap_vld_next = 1'b0;
        end

        mid_vld_next = mid_vld_reg;
        if (mid_load) begin
            mid_vld_next = 1'b1;
        end else if (out_free) begin
            mid_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (out_load) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_vld_reg <= 1'b0;
            mid_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            snap_vld_reg <= snap_vld_next;
            mid_vld_reg  <= mid_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers, loaded as each stage advances
    always_ff @(posedge aclk) begin
        if (snap_load) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                snap_sum_reg[i] <= lane_total[i];
            end
            snap_sf_reg <= s_s_frac;
            snap_tf_reg <= s_t_frac;
        end
        if (mid_load) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                top_reg[ch] <= top_val[ch];
                bot_reg[ch] <= bot_val[ch];
            end
            mid_tf_reg <= snap_tf_reg;
        end
        if (out_load) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                level_reg[ch] <= lvl_val[ch];
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_red_level   = level_reg[CH_RED];
    assign m_green_level = level_reg[CH_GREEN];
    assign m_blue_level  = level_reg[CH_BLUE];

    // a closing layer always lands in the snapshot stage
    `LBS_ASSERT_NEXT(a_last_fills_snap, snap_load, snap_vld_reg, "closing item lost before snapshot")
    // a held snapshot blocks further items
    `LBS_ASSERT_IMPLY(a_snap_blocks_input, snap_vld_reg && !mid_free, !s_ready, "input open over held snapshot")
    // a stalled middle stage keeps its result
    `LBS_ASSERT_NEXT(a_mid_holds, mid_vld_reg && out_vld_reg && !m_ready, mid_vld_reg, "middle stage dropped an item")

endmodule

`default_nettype wire

@@ design/lbs_mac_lane.sv @@
// one multiply-accumulate lane: texel times layer scale into a saturating sum
`default_nettype none

module lbs_mac_lane #(
    parameter int SCALE_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lbs_pkg::lane_ctl_t         ctl,
    input  logic [lbs_pkg::TEXEL_W-1:0] texel,
    input  logic [SCALE_BITS-1:0]      scale,
    output logic [lbs_pkg::SUM_W-1:0]  sum_total
);
    import lbs_pkg::*;

    localparam int PROD_W = TEXEL_W + SCALE_BITS;
    localparam int ADD_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    logic [PROD_W-1:0] prod;
    logic [ADD_W-1:0]  wide_sum;
    logic [SUM_W-1:0]  sat_sum;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    always_comb begin
        prod     = PROD_W'(texel) * PROD_W'(scale);
        wide_sum = ADD_W'(sum_reg) + ADD_W'(prod);
        sat_sum  = (wide_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_W-1:0];
        // running total including this item's layer
        sum_total = ctl.add ? sat_sum : sum_reg;
        sum_next  = sum_reg;
        if (ctl.accept) begin
            sum_next = ctl.clear ? '0 : sum_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

@@ design/lbs_lerp.sv @@
// one interpolation step: a plus floor of (b - a) times frac over 2^frac_bits
`default_nettype none

module lbs_lerp #(
    parameter int FRAC_BITS = 4
) (
    input  logic [lbs_pkg::SUM_W-1:0] a,
    input  logic [lbs_pkg::SUM_W-1:0] b,
    input  logic [FRAC_BITS-1:0]      frac,
    output logic [lbs_pkg::SUM_W-1:0] y
);
    import lbs_pkg::*;

    localparam int DIFF_W = SUM_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;
    logic signed [PROD_W-1:0] res;

    always_comb begin
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = PROD_W'(diff) * $signed(PROD_W'({1'b0, frac}));
        // arithmetic shift gives floor for negative differences
        step = prod >>> FRAC_BITS;
        res  = $signed(PROD_W'({1'b0, a})) + step;
        y    = res[SUM_W-1:0];
    end

endmodule

`default_nettype wire
